// File: rtl/tpr_pkg.sv
`default_nettype none

package tpr_pkg;

    localparam int FUNC_W     = 3;
    localparam int STEPS_W    = 10;
    localparam int ROW_IDX_W  = 6;
    localparam int ROW_BITS_W = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [FUNC_W-1:0] CMD_PEN_UP     = 3'd0;
    localparam logic [FUNC_W-1:0] CMD_PEN_DOWN   = 3'd1;
    localparam logic [FUNC_W-1:0] CMD_TURN_RIGHT = 3'd2;
    localparam logic [FUNC_W-1:0] CMD_TURN_LEFT  = 3'd3;
    localparam logic [FUNC_W-1:0] CMD_MOVE       = 3'd4;
    localparam logic [FUNC_W-1:0] CMD_DUMP       = 3'd5;

    localparam logic [1:0] HEAD_EAST  = 2'd0;
    localparam logic [1:0] HEAD_SOUTH = 2'd1;
    localparam logic [1:0] HEAD_WEST  = 2'd2;
    localparam logic [1:0] HEAD_NORTH = 2'd3;

    typedef enum logic [2:0] {
        OP_PEN_UP,
        OP_PEN_DOWN,
        OP_TURN_R,
        OP_TURN_L,
        OP_MOVE,
        OP_DUMP
    } t_op;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [STEPS_W-1:0] steps;
    } t_in_word;

    typedef struct packed {
        logic [ROW_IDX_W-1:0]  row_index;
        logic [ROW_BITS_W-1:0] row_bits;
        logic                  last;
    } t_out_word;

    typedef struct packed {
        t_op                op;
        logic [STEPS_W-1:0] steps;
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/turtle_plotter_raster_core.sv
// Turtle plotter on a GRID_ROWS x GRID_COLS one-bit raster.
// Command channel (i_cmd_valid/o_cmd_ready, i_cmd): func and steps. Pen,
// turn, move and dump words go through a decode stage and a four-word
// queue, so the sender keeps going while the executor works.
// Row channel (o_row_valid/i_row_ready, o_row): only dumps give words, one
// per raster row from row 0 upward, with last set on the final row.
// Pen and turn commands are executed straight from the idle state. A move
// visits cell by cell, with a raster read and then a write-back of the
// marked row when the pen is down; the walk ends early once the turtle is
// clamped at an edge. A dump streams one row per cycle while the receiver
// keeps i_row_ready high, through a single raster read port; its first row
// word passes the decode stage, the queue, the raster read and the output
// register in that order.
// Reset (i_rst_n low, synchronous) clears the raster through per-row valid
// flags at once, puts the turtle at (0,0) facing east with the pen up, and
// empties the queue. When the receiver holds i_row_ready low, the dump
// pauses with its row in the output register; the queue keeps taking words
// until it is full.
`default_nettype none

module turtle_plotter_raster_core #(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64
) (
    input  wire                    logic i_clk,
    input  wire                    logic i_rst_n,
    input  wire                    logic i_cmd_valid,
    output                         logic o_cmd_ready,
    input  wire tpr_pkg::t_in_word       i_cmd,
    output                         logic o_row_valid,
    input  wire                    logic i_row_ready,
    output tpr_pkg::t_out_word           o_row
);
    import tpr_pkg::*;

    logic fq_valid;
    logic fq_ready;
    t_cmd fq_cmd;
    logic qb_valid;
    logic qb_ready;
    t_cmd qb_cmd;

    tpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd_valid),
        .o_cmd_ready (o_cmd_ready),
        .i_cmd       (i_cmd),
        .o_q_valid   (fq_valid),
        .i_q_ready   (fq_ready),
        .o_q_cmd     (fq_cmd)
    );

    tpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_cmd   (fq_cmd),
        .o_valid (qb_valid),
        .i_ready (qb_ready),
        .o_cmd   (qb_cmd)
    );

    tpr_back #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (qb_valid),
        .o_q_ready   (qb_ready),
        .i_q_cmd     (qb_cmd),
        .o_row_valid (o_row_valid),
        .i_row_ready (i_row_ready),
        .o_row       (o_row)
    );

endmodule

`default_nettype wire

// File: rtl/tpr_front.sv
`default_nettype none

module tpr_front (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_cmd_valid,
    output                     logic o_cmd_ready,
    input  wire tpr_pkg::t_in_word i_cmd,
    output                     logic o_q_valid,
    input  wire                logic i_q_ready,
    output tpr_pkg::t_cmd            o_q_cmd
);
    import tpr_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    logic  accept;
    logic  keep;
    t_cmd  dec;

    // decode; unused codes and zero-step moves are dropped here
    always_comb begin
        keep      = 1'b1;
        dec.steps = '0;
        dec.op    = OP_PEN_UP;
        case (i_cmd.func)
            CMD_PEN_UP:     dec.op = OP_PEN_UP;
            CMD_PEN_DOWN:   dec.op = OP_PEN_DOWN;
            CMD_TURN_RIGHT: dec.op = OP_TURN_R;
            CMD_TURN_LEFT:  dec.op = OP_TURN_L;
            CMD_MOVE: begin
                dec.op    = OP_MOVE;
                dec.steps = i_cmd.steps;
                keep      = (i_cmd.steps != '0);
            end
            CMD_DUMP:       dec.op = OP_DUMP;
            default:        keep = 1'b0;
        endcase
    end

    assign o_cmd_ready = !r_valid || i_q_ready;
    assign accept      = i_cmd_valid && o_cmd_ready;
    assign o_q_valid   = r_valid;
    assign o_q_cmd     = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid <= keep;
            end else if (i_q_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= dec;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tpr_queue.sv
`default_nettype none

module tpr_queue (
    input  wire              logic i_clk,
    input  wire              logic i_rst_n,
    input  wire              logic i_valid,
    output                   logic o_ready,
    input  wire tpr_pkg::t_cmd     i_cmd,
    output                   logic o_valid,
    input  wire              logic i_ready,
    output tpr_pkg::t_cmd          o_cmd
);
    import tpr_pkg::*;

    t_cmd              r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_buf[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tpr_back.sv
`default_nettype none

module tpr_back #(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64
) (
    input  wire               logic i_clk,
    input  wire               logic i_rst_n,
    input  wire               logic i_q_valid,
    output                    logic o_q_ready,
    input  wire tpr_pkg::t_cmd      i_q_cmd,
    output                    logic o_row_valid,
    input  wire               logic i_row_ready,
    output tpr_pkg::t_out_word      o_row
);
    import tpr_pkg::*;

    localparam int XW = $clog2(GRID_COLS);
    localparam int YW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_ROWS + 1);

    localparam logic [XW-1:0]        X_MAX    = XW'(GRID_COLS - 1);
    localparam logic [YW-1:0]        Y_MAX    = YW'(GRID_ROWS - 1);
    localparam logic [CW-1:0]        ROWS_C   = CW'(GRID_ROWS);
    localparam logic [GRID_COLS-1:0] BIT_ONE  = GRID_COLS'(1);
    localparam logic [STEPS_W-1:0]   STEP_ONE = STEPS_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MV_RD,
        ST_MV_WR,
        ST_DUMP
    } t_state;

    t_state               r_state;
    logic                 r_pen;
    logic [1:0]           r_head;
    logic [XW-1:0]        r_pos_x;
    logic [YW-1:0]        r_pos_y;
    logic [STEPS_W-1:0]   r_steps;
    logic [CW-1:0]        r_row_cnt;
    logic                 r_rd_pend;
    logic [YW-1:0]        r_rd_row;
    logic                 r_out_valid;
    t_out_word            r_out;

    logic [GRID_COLS-1:0] r_mem [GRID_ROWS];
    logic [GRID_ROWS-1:0] r_row_valid;
    logic [GRID_COLS-1:0] r_rd_data;
    logic                 r_rd_hit;

    logic                 out_load;
    logic                 dump_issue;
    logic                 rd_en;
    logic [YW-1:0]        rd_addr;
    logic [GRID_COLS-1:0] rd_row;
    logic                 wr_en;
    logic                 blocked;
    logic [XW-1:0]        nx;
    logic [YW-1:0]        ny;
    logic                 move_done;

    assign out_load   = r_rd_pend && (!r_out_valid || i_row_ready);
    assign dump_issue = (r_state == ST_DUMP) && (r_row_cnt != ROWS_C)
                        && (!r_rd_pend || out_load);
    assign rd_en      = (r_state == ST_MV_RD) || dump_issue;
    assign rd_addr    = (r_state == ST_MV_RD) ? r_pos_y : r_row_cnt[YW-1:0];
    // rows never written since reset read as blank
    assign rd_row     = r_rd_hit ? r_rd_data : '0;
    assign wr_en      = (r_state == ST_MV_WR) && r_pen;

    assign o_q_ready   = (r_state == ST_IDLE);
    assign o_row_valid = r_out_valid;
    assign o_row       = r_out;

    // one-cell advance, clamped at the edge
    always_comb begin
        nx      = r_pos_x;
        ny      = r_pos_y;
        blocked = 1'b0;
        case (r_head)
            HEAD_EAST: begin
                blocked = (r_pos_x == X_MAX);
                nx      = r_pos_x + 1'b1;
            end
            HEAD_SOUTH: begin
                blocked = (r_pos_y == Y_MAX);
                ny      = r_pos_y + 1'b1;
            end
            HEAD_WEST: begin
                blocked = (r_pos_x == '0);
                nx      = r_pos_x - 1'b1;
            end
            default: begin
                blocked = (r_pos_y == '0);
                ny      = r_pos_y - 1'b1;
            end
        endcase
    end

    // once clamped at an edge, the walk ends after marking the current cell
    assign move_done = (r_steps == STEP_ONE) || blocked;

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_pos_y] <= rd_row | (BIT_ONE << r_pos_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_hit    <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_hit <= r_row_valid[rd_addr];
            end
            if (wr_en) begin
                r_row_valid[r_pos_y] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pen       <= 1'b0;
            r_head      <= HEAD_EAST;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_steps     <= '0;
            r_row_cnt   <= '0;
            r_rd_pend   <= 1'b0;
            r_rd_row    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid     <= 1'b1;
                r_out.row_index <= ROW_IDX_W'(r_rd_row);
                r_out.row_bits  <= ROW_BITS_W'(rd_row);
                r_out.last      <= (r_rd_row == Y_MAX);
            end else if (i_row_ready) begin
                r_out_valid <= 1'b0;
            end

            if (dump_issue) begin
                r_rd_pend <= 1'b1;
                r_rd_row  <= r_row_cnt[YW-1:0];
                r_row_cnt <= r_row_cnt + 1'b1;
            end else if (out_load) begin
                r_rd_pend <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        case (i_q_cmd.op)
                            OP_PEN_UP:   r_pen  <= 1'b0;
                            OP_PEN_DOWN: r_pen  <= 1'b1;
                            OP_TURN_R:   r_head <= r_head + 2'd1;
                            OP_TURN_L:   r_head <= r_head + 2'd3;
                            OP_MOVE: begin
                                r_steps <= i_q_cmd.steps;
                                r_state <= ST_MV_RD;
                            end
                            OP_DUMP: begin
                                r_row_cnt <= '0;
                                r_state   <= ST_DUMP;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MV_RD: begin
                    r_state <= ST_MV_WR;
                end
                ST_MV_WR: begin
                    if (move_done) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_pos_x <= nx;
                        r_pos_y <= ny;
                        r_steps <= r_steps - 1'b1;
                        r_state <= ST_MV_RD;
                    end
                end
                ST_DUMP: begin
                    if ((r_row_cnt == ROWS_C) && !r_rd_pend) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire
